### rtl/core/wpts_pkg.sv
// Shared constants and types for the white pixel third steering block.
// Used by the core and by its port checker; no dependencies.
package wpts_pkg;

   localparam int COUNT_BITS_DEF  = 22;
   localparam int COLUMN_BITS_DEF = 12;

   localparam int WIDTH_REG_BITS = 13;
   localparam int WIDTH_RESET    = 640;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;

   // word index of the image width register
   localparam logic CSR_IDX_IMAGE_WIDTH = 1'b0;

   localparam logic [7:0] WHITE_LEVEL = 8'hFF;

   typedef enum logic [1:0] {
      CMD_STOP    = 2'd0,
      CMD_LEFT    = 2'd1,
      CMD_FORWARD = 2'd2,
      CMD_RIGHT   = 2'd3
   } command_type;

endpackage

### rtl/core/white_pixel_third_steering_core.sv
// Top level of the white pixel third steering block: pixel counting per
// region, steering command per frame and the image width register.
// Depends on wpts_pkg.
//
// The result item appears in the cycle after its accepted frame_end pixel.
// Throughput: one pixel item per unstalled cycle; region compare, saturating
// count and column advance all resolve between the input ports and the state
// registers. The result register holds an item under rsp_stall; input is
// stalled only while a result waits and the output side stalls.
// Reset (synchronous, active high) clears column, counters and the result
// valid, and loads the image width register with 640.
module white_pixel_third_steering_core #(
   parameter int COUNT_BITS  = wpts_pkg::COUNT_BITS_DEF,
   parameter int COLUMN_BITS = wpts_pkg::COLUMN_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_red,
   input  logic [7:0]                          req_green,
   input  logic [7:0]                          req_blue,
   input  logic                                req_frame_end,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_command,
   output logic [COUNT_BITS-1:0]               rsp_left_count,
   output logic [COUNT_BITS-1:0]               rsp_middle_count,
   output logic [COUNT_BITS-1:0]               rsp_right_count,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wpts_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [wpts_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [wpts_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);

   localparam int RB = wpts_pkg::WIDTH_REG_BITS;
   // effective width spans 1 .. 2^COLUMN_BITS
   localparam int WB = COLUMN_BITS + 1;
   // wide enough for both the raw register and the clamp bound
   localparam int EB = (WB > RB) ? WB : RB;
   // divide-by-three operand (twice the width) and reciprocal scale
   localparam int NB = COLUMN_BITS + 2;
   localparam int SB = NB + 2;
   localparam int PB = NB + SB;
   localparam logic [SB-1:0] RECIP = SB'((2 ** SB) / 3 + 1);
   localparam logic [EB-1:0] WMAX  = EB'(1) << COLUMN_BITS;
   localparam int RESET_EFF = (wpts_pkg::WIDTH_RESET > (2 ** COLUMN_BITS)) ?
                              (2 ** COLUMN_BITS) : wpts_pkg::WIDTH_RESET;
   localparam logic [WB-1:0] RESET_WIDTH = WB'(RESET_EFF);
   localparam logic [WB-1:0] RESET_LEFT  = WB'(RESET_EFF / 3);
   localparam logic [WB-1:0] RESET_MID   = WB'((2 * RESET_EFF) / 3);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // ---------------------------------------------------------------------
   // Configuration: keep the raw value for reads, and derive the clamped
   // width and both region bounds at write time.
   // ---------------------------------------------------------------------
   logic [RB-1:0] width_raw_ff;
   logic [WB-1:0] width_eff_ff, left_lim_ff, mid_lim_ff;
   logic          csr_wr;
   logic [EB-1:0] wr_raw_ext, wr_clamp;
   logic [WB-1:0] wr_eff;
   logic [PB-1:0] left_prod, mid_prod;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready &&
                   (paddr[2] == wpts_pkg::CSR_IDX_IMAGE_WIDTH);

   always_comb begin
      wr_raw_ext = EB'(pwdata[RB-1:0]);
      if (wr_raw_ext == '0) begin
         wr_clamp = EB'(1);
      end else if (wr_raw_ext > WMAX) begin
         wr_clamp = WMAX;
      end else begin
         wr_clamp = wr_raw_ext;
      end
      wr_eff = wr_clamp[WB-1:0];
      // floor(x/3) as (x * RECIP) >> SB, exact for x below 2^NB
      left_prod = PB'(wr_eff) * PB'(RECIP);
      mid_prod  = PB'({wr_eff, 1'b0}) * PB'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff <= RB'(wpts_pkg::WIDTH_RESET);
         width_eff_ff <= RESET_WIDTH;
         left_lim_ff  <= RESET_LEFT;
         mid_lim_ff   <= RESET_MID;
      end else if (csr_wr) begin
         width_raw_ff <= pwdata[RB-1:0];
         width_eff_ff <= wr_eff;
         left_lim_ff  <= left_prod[SB +: WB];
         mid_lim_ff   <= mid_prod[SB +: WB];
      end
   end

   assign prdata = wpts_pkg::CSR_DATA_BITS'(width_raw_ff);

   // ---------------------------------------------------------------------
   // Pixel path: classify, count and advance the column on each item.
   // ---------------------------------------------------------------------
   logic                   req_accept;
   logic                   is_white;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic [WB-1:0]          column_ext, column_plus;
   logic [COUNT_BITS-1:0]  left_ff, middle_ff, right_ff;
   logic [COUNT_BITS-1:0]  left_new, middle_new, right_new;
   logic [COUNT_BITS-1:0]  left_in, middle_in, right_in;

   // hold the input only while a finished result waits on a stalled output
   assign req_stall  = rsp_valid && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign is_white = (req_red == wpts_pkg::WHITE_LEVEL) &&
                     (req_green == wpts_pkg::WHITE_LEVEL) &&
                     (req_blue == wpts_pkg::WHITE_LEVEL);

   always_comb begin
      column_ext  = WB'(column_ff);
      column_plus = column_ext + WB'(1);
      left_new    = left_ff;
      middle_new  = middle_ff;
      right_new   = right_ff;
      if (is_white) begin
         // a column past a lowered width falls through to the right region
         if (column_ext <= left_lim_ff) begin
            if (left_ff != COUNT_MAX) left_new = left_ff + COUNT_BITS'(1);
         end else if (column_ext <= mid_lim_ff) begin
            if (middle_ff != COUNT_MAX) middle_new = middle_ff + COUNT_BITS'(1);
         end else begin
            if (right_ff != COUNT_MAX) right_new = right_ff + COUNT_BITS'(1);
         end
      end
      // wrap at the row end, and restart the row at frame end
      if (req_frame_end || (column_plus >= width_eff_ff)) begin
         column_in = '0;
      end else begin
         column_in = column_plus[COLUMN_BITS-1:0];
      end
      // clear the counters once a frame's totals move to the result
      if (req_frame_end) begin
         left_in   = '0;
         middle_in = '0;
         right_in  = '0;
      end else begin
         left_in   = left_new;
         middle_in = middle_new;
         right_in  = right_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         left_ff   <= '0;
         middle_ff <= '0;
         right_ff  <= '0;
      end else if (req_accept) begin
         column_ff <= column_in;
         left_ff   <= left_in;
         middle_ff <= middle_in;
         right_ff  <= right_in;
      end
   end

   // ---------------------------------------------------------------------
   // Command choice: stop on an empty frame, else the first maximum in the
   // order left, middle, right.
   // ---------------------------------------------------------------------
   wpts_pkg::command_type command_in;

   always_comb begin
      if ((left_new == '0) && (middle_new == '0) && (right_new == '0)) begin
         command_in = wpts_pkg::CMD_STOP;
      end else if ((left_new >= middle_new) && (left_new >= right_new)) begin
         command_in = wpts_pkg::CMD_LEFT;
      end else if (middle_new >= right_new) begin
         command_in = wpts_pkg::CMD_FORWARD;
      end else begin
         command_in = wpts_pkg::CMD_RIGHT;
      end
   end

   // ---------------------------------------------------------------------
   // Result register: load on a frame end item, drop once taken.
   // ---------------------------------------------------------------------
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   wpts_pkg::command_type command_ff;
   logic [COUNT_BITS-1:0] left_out_ff, middle_out_ff, right_out_ff;

   assign rsp_load = req_accept && req_frame_end;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         command_ff    <= command_in;
         left_out_ff   <= left_new;
         middle_out_ff <= middle_new;
         right_out_ff  <= right_new;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command      = command_ff;
   assign rsp_left_count   = left_out_ff;
   assign rsp_middle_count = middle_out_ff;
   assign rsp_right_count  = right_out_ff;

endmodule

### rtl/core/wpts_checker.sv
// Port-level checker for the white pixel third steering core, with its bind.
// Depends on wpts_pkg and the core's port list.
module wpts_checker #(
   parameter int COUNT_BITS = wpts_pkg::COUNT_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  req_frame_end,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [1:0]            rsp_command,
   input logic [COUNT_BITS-1:0] rsp_left_count,
   input logic [COUNT_BITS-1:0] rsp_middle_count,
   input logic [COUNT_BITS-1:0] rsp_right_count
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command) &&
         $stable(rsp_left_count) && $stable(rsp_middle_count) &&
         $stable(rsp_right_count))
      else $error("stalled result item changed");

   // every accepted frame end item yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_frame_end |=> rsp_valid)
      else $error("frame end item gave no result");

   // a mid-frame item never invents a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_frame_end && !(rsp_valid && rsp_stall)
         |=> !rsp_valid)
      else $error("result without frame end");

   // stop only for a frame with no white pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == wpts_pkg::CMD_STOP) |->
         (rsp_left_count == '0) && (rsp_middle_count == '0) &&
         (rsp_right_count == '0))
      else $error("stop command with nonzero counts");

endmodule

bind white_pixel_third_steering_core wpts_checker #(
   .COUNT_BITS(COUNT_BITS)
) u_wpts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_frame_end   (req_frame_end),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_command     (rsp_command),
   .rsp_left_count  (rsp_left_count),
   .rsp_middle_count(rsp_middle_count),
   .rsp_right_count (rsp_right_count)
);
